>>> rtl/core/button_click_hold_detector_assert.svh
// Assertion macros used by the button gesture detector core.
// Depends on nothing; expects i_clk and i_rst_n in the using module.
`ifndef BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_ASSERT_SVH

// The consequence must hold in the same cycle as the antecedent.
`define BCHD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequence must hold in the cycle after the antecedent.
`define BCHD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/bchd_pkg.sv
// Types and constants of the button click and hold detector.
// Depends on nothing; imported by bchd_core and the top level.
package bchd_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE    = 2'd0,
        CFG_DOUBLECLICK = 2'd1,
        CFG_ACTIVE_LOW  = 2'd2,
        CFG_ENABLED     = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DOWN1 = 3'd1,
        PH_UP1   = 3'd2,
        PH_DOWN2 = 3'd3,
        PH_UP2   = 3'd4,
        PH_HOLD1 = 3'd5,
        PH_HOLD2 = 3'd6
    } t_phase;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] doubleclick_ms;
        logic        active_low;
        logic        enabled;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              level;
    } t_in;

    typedef struct packed {
        logic       press_event;
        logic       single_hold_event;
        logic       double_hold_event;
        logic       hold_ended_event;
        logic       single_click_event;
        logic       double_click_event;
        logic       pressed;
        logic [2:0] gesture_state;
    } t_out;

    localparam logic [15:0] DEBOUNCE_RST    = 16'd50;
    localparam logic [15:0] DOUBLECLICK_RST = 16'd300;

endpackage

>>> rtl/core/bchd_core.sv
// Gesture state and per-poll update logic of the button detector.
// Depends on bchd_pkg and button_click_hold_detector_assert.svh.
`include "button_click_hold_detector_assert.svh"

module bchd_core import bchd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_step,
    input  t_cfg i_cfg,
    input  t_in  i_item,
    output t_out o_res
);

    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_first_down, n_first_down;
    logic [TIME_W-1:0] r_second_down, n_second_down;
    logic [TIME_W-1:0] r_quiet_until, n_quiet_until;
    logic              r_last_level, n_last_level;

    logic              act;
    logic              take;
    logic [TIME_W-1:0] quiet_end;

    assign act       = ~i_cfg.active_low;
    assign take      = i_cfg.enabled && (i_item.now_ms >= r_quiet_until);
    assign quiet_end = i_item.now_ms + {{(TIME_W-16){1'b0}}, i_cfg.debounce_ms};

    // The level before this poll is simply the stored last level, so it
    // needs no register of its own.
    always_comb begin
        n_phase       = r_phase;
        n_first_down  = r_first_down;
        n_second_down = r_second_down;
        n_quiet_until = r_quiet_until;
        n_last_level  = r_last_level;
        o_res         = '0;
        if (take) begin
            n_last_level = i_item.level;
            if (i_item.level == act) begin
                if (r_last_level != act) begin
                    n_quiet_until     = quiet_end;
                    o_res.press_event = 1'b1;
                    if (r_phase == PH_IDLE) begin
                        n_first_down = i_item.now_ms;
                        n_phase      = PH_DOWN1;
                    end else if (r_phase == PH_UP1) begin
                        n_second_down = i_item.now_ms;
                        n_phase       = PH_DOWN2;
                    end
                end
                // Hold checks see the press time just stored on this poll.
                if (n_phase == PH_DOWN1 && i_item.now_ms >=
                        n_first_down + {{(TIME_W-16){1'b0}}, i_cfg.doubleclick_ms}) begin
                    n_phase                 = PH_HOLD1;
                    o_res.single_hold_event = 1'b1;
                end else if (n_phase == PH_DOWN2 && i_item.now_ms >=
                        n_second_down + {{(TIME_W-16){1'b0}}, i_cfg.doubleclick_ms}) begin
                    n_phase                 = PH_HOLD2;
                    o_res.double_hold_event = 1'b1;
                end
            end else begin
                if (r_last_level == act) begin
                    n_quiet_until = quiet_end;
                    case (r_phase)
                        PH_DOWN1: n_phase = PH_UP1;
                        PH_DOWN2: n_phase = PH_UP2;
                        PH_HOLD1, PH_HOLD2: begin
                            n_phase                = PH_IDLE;
                            o_res.hold_ended_event = 1'b1;
                        end
                        default: n_phase = r_phase;
                    endcase
                end
                if (n_phase == PH_UP1 && i_item.now_ms >=
                        r_first_down + {{(TIME_W-16){1'b0}}, i_cfg.doubleclick_ms}) begin
                    n_phase                  = PH_IDLE;
                    o_res.single_click_event = 1'b1;
                end else if (n_phase == PH_UP2) begin
                    n_phase                  = PH_IDLE;
                    o_res.double_click_event = 1'b1;
                end
            end
        end
        o_res.pressed       = (n_last_level == act);
        o_res.gesture_state = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_first_down  <= '0;
            r_second_down <= '0;
            r_quiet_until <= '0;
            r_last_level  <= 1'b1;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_first_down  <= n_first_down;
            r_second_down <= n_second_down;
            r_quiet_until <= n_quiet_until;
            r_last_level  <= n_last_level;
        end
    end

    `BCHD_ASSERT_NOW(a_hold_end_idle, i_step && o_res.hold_ended_event,
        o_res.gesture_state == PH_IDLE, "hold end without return to idle")
    `BCHD_ASSERT_NOW(a_one_click, i_step,
        !(o_res.single_click_event && o_res.double_click_event),
        "single and double click in one poll")
    `BCHD_ASSERT_NEXT(a_hold1_state, i_step && o_res.single_hold_event,
        r_phase == PH_HOLD1, "single hold did not enter hold state")
    `BCHD_ASSERT_NOW(a_ignored_quiet, i_step && !take,
        o_res == {6'b0, r_last_level == act, r_phase}, "ignored poll changed results")

endmodule

>>> rtl/core/button_click_hold_detector.sv
// Top level of the debounced button single/double click and hold detector.
// Depends on bchd_pkg and bchd_core.

// Each input item is one poll of the button (millisecond timestamp and raw
// level) and gives exactly one result item with six event flags, the pressed
// level and the gesture state. The block takes one item every clock cycle
// unless the output side stalls: an item sits in the input register, is
// evaluated by the gesture logic in bchd_core and moves to the result register
// when the output side can take it, so the result passes the input and result
// registers in turn. A stalled output holds the item in the input register.
// Configuration (debounce and double-click windows, active level, enable) is written through its own port,
// always ready; the user must write it only while the block is idle, and the block does not enforce this.
module button_click_hold_detector import bchd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    t_in  r_in_item;
    logic r_in_valid;
    t_out r_out_item;
    logic r_out_valid;
    t_out res;
    logic advance;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= DEBOUNCE_RST;
            r_cfg.doubleclick_ms <= DOUBLECLICK_RST;
            r_cfg.active_low     <= 1'b1;
            r_cfg.enabled        <= 1'b1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE:    r_cfg.debounce_ms    <= i_cfg_data;
                CFG_DOUBLECLICK: r_cfg.doubleclick_ms <= i_cfg_data;
                CFG_ACTIVE_LOW:  r_cfg.active_low     <= i_cfg_data[0];
                CFG_ENABLED:     r_cfg.enabled        <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (advance) begin
            r_out_item <= res;
        end
    end

    bchd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_cfg   (r_cfg),
        .i_item  (r_in_item),
        .o_res   (res)
    );

endmodule
